### design/wdt_pkg.sv
package wdt_pkg;

	localparam int NUM_CHANNELS = 8;

	// field widths of the request word
	localparam int REQ_W = 3;
	localparam int CH_W  = 4;
	localparam int TMO_W = 16;

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
	localparam logic [CH_W:0] NUM_CH_EXT = (CH_W + 1)'(NUM_CHANNELS);

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK    = 3'd0,
		REQ_START   = 3'd1,
		REQ_FEED    = 3'd2,
		REQ_SUSPEND = 3'd3,
		REQ_RESUME  = 3'd4,
		REQ_CLEAR   = 3'd5
	} req_code_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_SUSP = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WALK,
		ST_CLEAR
	} wdt_state_t;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [CH_W-1:0]  channel;
		logic [TMO_W-1:0] timeout_value;
	} wdt_req_t;

	typedef struct packed {
		logic start_ok;
		logic feed_allowed;
	} wdt_res_t;

	// one channel entry of the table
	typedef struct packed {
		mode_t            mode;
		logic [TMO_W-1:0] tmo;
		logic [TMO_W-1:0] cnt;
	} wdt_entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		wdt_entry_t       ent;
	} wdt_wr_t;

	typedef struct packed {
		logic     done;
		wdt_res_t res;
	} wdt_fin_t;

endpackage

### design/wdt_table.sv
module wdt_table import wdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output wdt_entry_t       rd_ent,
	input  wdt_wr_t          wr
);

	wdt_entry_t ent_q [NUM_CHANNELS];

	// one write port, cleared to idle at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CHANNELS; k++) begin
				ent_q[k] <= '{mode: MODE_IDLE, tmo: '0, cnt: '0};
			end
		end else if (wr.en) begin
			ent_q[wr.idx] <= wr.ent;
		end
	end

	assign rd_ent = ent_q[rd_idx];

endmodule

### design/wdt_ctrl.sv
module wdt_ctrl import wdt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  wdt_req_t         req,
	output logic             busy,
	output logic [IDX_W-1:0] rd_idx,
	input  wdt_entry_t       rd_ent,
	output wdt_wr_t          wr,
	output wdt_fin_t         fin
);

	wdt_state_t       state_q, state_d;
	wdt_req_t         req_q;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             flag_q, flag_d;
	logic             in_range;
	logic [TMO_W-1:0] dec;

	assign busy     = (state_q != ST_IDLE);
	assign in_range = ({1'b0, req_q.channel} < NUM_CH_EXT);
	// shared decrement unit, one channel per cycle
	assign dec      = rd_ent.cnt - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			flag_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			flag_q  <= flag_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
	end

	always_comb begin
		state_d              = state_q;
		idx_d                = idx_q;
		flag_d               = flag_q;
		rd_idx               = idx_q;
		wr.en                = 1'b0;
		wr.idx               = idx_q;
		wr.ent               = rd_ent;
		fin.done             = 1'b0;
		fin.res.start_ok     = 1'b0;
		fin.res.feed_allowed = flag_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				rd_idx   = req_q.channel[IDX_W-1:0];
				wr.idx   = req_q.channel[IDX_W-1:0];
				fin.done = 1'b1;
				state_d  = ST_IDLE;
				unique case (req_q.req_type)
					REQ_TICK: begin
						if (flag_q) begin
							fin.done = 1'b0;
							idx_d    = '0;
							state_d  = ST_WALK;
						end
					end
					REQ_START: begin
						if (in_range && rd_ent.mode == MODE_IDLE) begin
							wr.en            = 1'b1;
							wr.ent.mode      = MODE_RUN;
							wr.ent.tmo       = req_q.timeout_value;
							wr.ent.cnt       = req_q.timeout_value;
							fin.res.start_ok = 1'b1;
						end
					end
					REQ_FEED: begin
						wr.en      = in_range;
						wr.ent.cnt = rd_ent.tmo;
					end
					REQ_SUSPEND: begin
						wr.en       = in_range;
						wr.ent.mode = MODE_SUSP;
					end
					REQ_RESUME: begin
						wr.en       = in_range;
						wr.ent.mode = MODE_RUN;
					end
					REQ_CLEAR: begin
						fin.done = 1'b0;
						idx_d    = '0;
						state_d  = ST_CLEAR;
					end
					default: begin
						// unused codes answer with the current flag
					end
				endcase
			end
			ST_WALK: begin
				idx_d = idx_q + 1'b1;
				if (rd_ent.mode == MODE_RUN) begin
					wr.en      = 1'b1;
					wr.ent.cnt = dec;
				end
				if (rd_ent.mode == MODE_RUN && dec == '0) begin
					// first expiry trips the watchdog and ends the walk
					flag_d               = 1'b0;
					fin.done             = 1'b1;
					fin.res.feed_allowed = 1'b0;
					state_d              = ST_IDLE;
				end else if (idx_q == LAST_IDX) begin
					fin.done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				idx_d  = idx_q + 1'b1;
				wr.en  = 1'b1;
				wr.ent = '{mode: MODE_IDLE, tmo: '0, cnt: '0};
				if (idx_q == LAST_IDX) begin
					flag_d               = 1'b1;
					fin.done             = 1'b1;
					fin.res.feed_allowed = 1'b1;
					state_d              = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// every finished request goes back to idle
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin.done |=> state_q == ST_IDLE)
		else $error("request finished without returning to idle");

	// only a start request reports success
	a_ok_start: assert property (@(posedge clk) disable iff (!arst_n)
		fin.done && fin.res.start_ok |-> req_q.req_type == REQ_START)
		else $error("start_ok on a request that is not a start");

	// the flag drops only during a tick walk
	a_flag_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(flag_q) |-> $past(state_q) == ST_WALK)
		else $error("feed flag cleared outside a tick walk");

	// table writes happen only while a request is in progress
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> busy)
		else $error("table write while idle");

endmodule

### design/multi_channel_task_watchdog.sv
// start, feed, suspend, resume and unused codes finish in the exec state, then the result word is registered
// a tick with the flag set, and clear-all, walk the table from channel 0 (one channel/cycle)
// a tick with the flag off finishes in the exec state, like the single-channel codes
// busy falls as the result word is shown, so the next word may be accepted in that same cycle
// the receiver cannot stall: done is a single-cycle strobe
// reset: all channels idle with timeout and count 0, feeding enabled
module multi_channel_task_watchdog import wdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  wdt_req_t req,
	output logic     busy,
	output logic     done,
	output wdt_res_t res
);

	logic [IDX_W-1:0] rd_idx;
	wdt_entry_t       rd_ent;
	wdt_wr_t          wr;
	wdt_fin_t         fin;
	logic             done_q;
	wdt_res_t         res_q;

	// sequencer: decodes the request word and walks the table for ticks and clears
	wdt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.rd_idx (rd_idx),
		.rd_ent (rd_ent),
		.wr     (wr),
		.fin    (fin)
	);

	// per-channel mode, timeout and count
	wdt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_idx (rd_idx),
		.rd_ent (rd_ent),
		.wr     (wr)
	);

	// result word register, strobe lasts one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= fin.done;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.done) begin
			res_q <= fin.res;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

### tb/wdt_checker.sv
`timescale 1ns / 1ps

module wdt_checker import wdt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  wdt_req_t req,
	input  logic     done,
	input  wdt_res_t res,
	output int       mismatches,
	output int       outstanding
);

	// shadow copy of the channel table
	mode_t            shadow_mode [NUM_CHANNELS];
	logic [TMO_W-1:0] shadow_tmo  [NUM_CHANNELS];
	logic [TMO_W-1:0] shadow_cnt  [NUM_CHANNELS];
	logic             shadow_feed;

	wdt_res_t expected_res_q [$];
	wdt_res_t want;
	int       fail_total;

	task automatic clear_shadow_table();
		for (int k = 0; k < NUM_CHANNELS; k++) begin
			shadow_mode[k] = MODE_IDLE;
			shadow_tmo[k]  = '0;
			shadow_cnt[k]  = '0;
		end
		shadow_feed = 1'b1;
	endtask

	task automatic predict_response(input wdt_req_t r, output wdt_res_t w);
		logic in_range;
		logic tripped;
		int   ch;
		in_range = (r.channel < NUM_CHANNELS);
		ch       = in_range ? int'(r.channel) : 0;
		tripped  = 1'b0;
		w.start_ok = 1'b0;
		case (r.req_type)
			REQ_TICK: begin
				if (shadow_feed) begin
					for (int k = 0; k < NUM_CHANNELS && !tripped; k++) begin
						if (shadow_mode[k] == MODE_RUN) begin
							shadow_cnt[k] = shadow_cnt[k] - 1'b1;
							if (shadow_cnt[k] == '0) begin
								shadow_feed = 1'b0;
								tripped     = 1'b1;
							end
						end
					end
				end
			end
			REQ_START: begin
				if (in_range && shadow_mode[ch] == MODE_IDLE) begin
					shadow_tmo[ch]  = r.timeout_value;
					shadow_cnt[ch]  = r.timeout_value;
					shadow_mode[ch] = MODE_RUN;
					w.start_ok      = 1'b1;
				end
			end
			REQ_FEED: if (in_range) shadow_cnt[ch] = shadow_tmo[ch];
			REQ_SUSPEND: if (in_range) shadow_mode[ch] = MODE_SUSP;
			REQ_RESUME: if (in_range) shadow_mode[ch] = MODE_RUN;
			REQ_CLEAR: clear_shadow_table();
			default: ;
		endcase
		w.feed_allowed = shadow_feed;
	endtask

	initial begin
		fail_total  = 0;
		mismatches  = 0;
		outstanding = 0;
		clear_shadow_table();
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_shadow_table();
			expected_res_q.delete();
			outstanding <= 0;
		end else begin
			// the result of an older word is checked before a new word is predicted
			if (done) begin
				if (expected_res_q.size() == 0) begin
					$display("%0t: result word with none expected, actual %b", $time, res);
					fail_total++;
				end else begin
					want = expected_res_q.pop_front();
					if (res.start_ok !== want.start_ok) begin
						$display("%0t: start_ok expected %b actual %b",
							$time, want.start_ok, res.start_ok);
						fail_total++;
					end
					if (res.feed_allowed !== want.feed_allowed) begin
						$display("%0t: feed_allowed expected %b actual %b",
							$time, want.feed_allowed, res.feed_allowed);
						fail_total++;
					end
				end
			end
			if (start && !busy) begin
				predict_response(req, want);
				expected_res_q.push_back(want);
			end
			outstanding <= expected_res_q.size();
			mismatches  <= fail_total;
		end
	end

endmodule

### tb/tb_multi_channel_task_watchdog.sv
`timescale 1ns / 1ps

module tb_multi_channel_task_watchdog;
	import wdt_pkg::*;

	// unused request codes, the block must answer them without any change
	localparam logic [REQ_W-1:0] REQ_UNUSED_6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_UNUSED_7 = 3'd7;

	localparam int WORDS_PER_PHASE = 400;
	localparam int MAX_GAP         = NUM_CHANNELS + 4;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	logic     done;
	wdt_req_t req;
	wdt_res_t res;
	int       mismatches;
	int       outstanding;

	multi_channel_task_watchdog DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.res    (res)
	);

	wdt_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req         (req),
		.done        (done),
		.res         (res),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	// present one word at the falling edge and hold it until the block takes it
	task automatic send_word(input logic [REQ_W-1:0] code, input logic [CH_W-1:0] ch,
			input logic [TMO_W-1:0] tmo);
		wdt_req_t w;
		w.req_type      = code;
		w.channel       = ch;
		w.timeout_value = tmo;
		@(negedge clk);
		start <= 1'b1;
		req   <= w;
		// busy sampled at the rising edge tells whether the word went in
		do @(posedge clk); while (busy);
	endtask

	// drop start and stay quiet for the number of cycles given
	task automatic go_idle(input int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// hold off until every predicted word has come back
	task automatic drain_results();
		go_idle(1);
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// random word, mostly well-formed traffic on in-range channels
	task automatic random_word();
		int                 pick;
		logic [REQ_W-1:0]   code;
		logic [CH_W-1:0]    ch;
		logic [TMO_W-1:0]   tmo;
		pick = $urandom_range(99);
		if (pick < 35)      code = REQ_TICK;
		else if (pick < 55) code = REQ_START;
		else if (pick < 70) code = REQ_FEED;
		else if (pick < 79) code = REQ_SUSPEND;
		else if (pick < 88) code = REQ_RESUME;
		else if (pick < 95) code = REQ_CLEAR;
		else                code = ($urandom_range(1)) ? REQ_UNUSED_7 : REQ_UNUSED_6;
		// out-of-range channels now and then
		if ($urandom_range(9) == 0) ch = CH_W'($urandom_range(15));
		else                        ch = CH_W'($urandom_range(NUM_CHANNELS - 1));
		// short timeouts so channels actually expire, full range sometimes
		pick = $urandom_range(99);
		if (pick < 60)      tmo = TMO_W'($urandom_range(15));
		else if (pick < 85) tmo = TMO_W'($urandom_range(300));
		else                tmo = TMO_W'($urandom());
		send_word(code, ch, tmo);
	endtask

	initial begin
		int idle_pct [3];
		idle_pct = '{0, 45, 11};

		start  = 1'b0;
		req    = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero timeout, start on a busy channel, out of range
		send_word(REQ_START,    4'd0,  16'd0);
		send_word(REQ_START,    4'd0,  16'd5);
		send_word(REQ_START,    4'd15, 16'd3);
		send_word(REQ_START,    4'd8,  16'd3);
		send_word(REQ_START,    4'd7,  16'hFFFF);
		// count 0 wraps to 65535 on this tick, no trip
		send_word(REQ_TICK,     4'd0,  16'd0);
		send_word(REQ_FEED,     4'd0,  16'd0);
		send_word(REQ_SUSPEND,  4'd0,  16'd0);
		send_word(REQ_TICK,     4'd0,  16'd0);
		send_word(REQ_RESUME,   4'd0,  16'd0);
		// resume on an idle channel starts it with stale count
		send_word(REQ_RESUME,   4'd3,  16'd0);
		send_word(REQ_FEED,     4'd15, 16'd0);
		send_word(REQ_SUSPEND,  4'd8,  16'd0);
		send_word(REQ_RESUME,   4'd9,  16'd0);
		send_word(REQ_UNUSED_6, 4'd2,  16'hAAAA);
		send_word(REQ_UNUSED_7, 4'd5,  16'h5555);
		// channel with timeout 1 trips on the next tick
		send_word(REQ_START,    4'd1,  16'd1);
		send_word(REQ_TICK,     4'd0,  16'd0);
		// flag off: ticks do nothing
		send_word(REQ_TICK,     4'd0,  16'd0);
		send_word(REQ_START,    4'd2,  16'd2);
		send_word(REQ_FEED,     4'd1,  16'd0);
		send_word(REQ_CLEAR,    4'd0,  16'd0);
		send_word(REQ_START,    4'd0,  16'd0);
		send_word(REQ_TICK,     4'd0,  16'd0);
		send_word(REQ_CLEAR,    4'd15, 16'hFFFF);
		drain_results();

		// random phases, each with its own chance of a sender gap, draining between them
		for (int ph = 0; ph < 3; ph++) begin
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				random_word();
				if (idle_pct[ph] != 0 && $urandom_range(99) < idle_pct[ph])
					go_idle($urandom_range(MAX_GAP, 1));
			end
			drain_results();
		end

		// let the block settle after the last word
		repeat (NUM_CHANNELS + 4) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
